@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the radix digit converter.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled during reset, generic message
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Clocked property, disabled during reset, caller-supplied message
`define ASSERT_CLK_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_CLK_MSG(label, prop, msg)

`endif

`endif

@@ rtl/core/rdc_pkg.sv @@
// Package for the radix digit converter: field widths, reset values, sequencer states.
// No dependencies.
package rdc_pkg;

    // Fixed width of the value, radix and digit fields
    localparam int FIELD_W = 31;

    // Configuration port
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // Radix reset value and smallest usable base
    localparam logic [FIELD_W-1:0] RADIX_RESET = FIELD_W'(10);
    localparam logic [FIELD_W-1:0] RADIX_MIN   = FIELD_W'(2);

    // Conversion sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_RD,
        ST_OUT
    } rdc_state_t;

endpackage

@@ rtl/core/rdc_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rdc_pkg (FIELD_W) and assert_macros.svh.
`include "assert_macros.svh"

module rdc_divider
    import rdc_pkg::*;
#(
    parameter int DW = 31
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DW-1:0]      dividend,
    input  logic [FIELD_W-1:0] divisor,
    output logic [DW-1:0]      quotient,
    output logic [FIELD_W-1:0] remainder,
    output logic               done
);

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic [FIELD_W-1:0] rem_reg, rem_next;
    logic [DW-1:0]      quo_reg, quo_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    logic [FIELD_W:0]   partial;
    logic [FIELD_W:0]   diff;
    logic               fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        partial = {rem_reg, quo_reg[DW-1]};
        fits    = (partial >= {1'b0, divisor});
        diff    = partial - {1'b0, divisor};
    end

    // Step control
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CW'(DW - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[FIELD_W-1:0] : partial[FIELD_W-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    `ASSERT_CLK_MSG(a_rem_below_divisor, run_reg |-> (rem_reg < divisor),
        "partial remainder not below divisor")
    `ASSERT_CLK(a_done_ends_run, done_reg |-> !run_reg)
    `ASSERT_CLK(a_done_after_last_step, done_reg |-> $past(run_reg) && $past(cnt_reg) == '0)

endmodule

@@ rtl/core/radix_digit_converter.sv @@
// Top level of the radix digit converter: APB radix register, sequencer, digit store.
// Depends on rdc_pkg, rdc_divider and assert_macros.svh.
//
//  channel   signals                                   direction
//  --------  ----------------------------------------  ---------
//  input     start, busy, value                        in (busy out)
//  result    digit_valid, digit, last_digit            out
//  config    psel penable pwrite paddr pwdata prdata   APB slave
//
// A word is accepted when start is high and busy is low; busy stays high
// until the final digit has been sent.
// Each digit is computed in the shared bit-serial divider, then sent by a
// store read followed by output. Digits appear most significant first,
// one cycle each with digit_valid; the receiver cannot stall. Reset sets
// the radix to 10 and idles the block.
`include "assert_macros.svh"

module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input word
    input  logic                  start,
    output logic                  busy,
    input  logic [FIELD_W-1:0]    value,
    // result word
    output logic                  digit_valid,
    output logic [FIELD_W-1:0]    digit,
    output logic                  last_digit,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    rdc_state_t          state_reg, state_next;
    logic [FIELD_W-1:0]  radix_reg;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [FIELD_W-1:0]  rd_data_reg;

    logic [FIELD_W-1:0]  digit_store [MAX_DIGITS];

    logic [FIELD_W+VALUE_BITS-1:0] value_ext;
    logic [FIELD_W-1:0]  base_eff;
    logic                div_start;
    logic                div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic [FIELD_W-1:0]  div_rem;
    logic                mem_wr;
    logic                mem_rd;
    logic [CNT_W-1:0]    cnt_inc;

    // APB register: any write updates the radix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            radix_reg <= pwdata[FIELD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {{(APB_DATA_W - FIELD_W){1'b0}}, radix_reg};

    // Bases below two act as two
    assign base_eff  = (radix_reg < RADIX_MIN) ? RADIX_MIN : radix_reg;
    assign value_ext = {{VALUE_BITS{1'b0}}, value};
    assign cnt_inc   = cnt_reg + 1'b1;

    // Shared divider
    rdc_divider #(
        .DW(VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (q_reg),
        .divisor   (base_eff),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Sequencer: divide until the quotient is zero or the store is full, then send the stored digits back
    always_comb
    begin
        state_next = state_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        div_start  = 1'b0;
        mem_wr     = 1'b0;
        mem_rd     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    q_next     = value_ext[VALUE_BITS-1:0];
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mem_wr   = 1'b1;
                    q_next   = div_quo;
                    cnt_next = cnt_inc;
                    if (div_quo == '0 || cnt_inc == CNT_W'(MAX_DIGITS))
                    begin
                        ptr_next   = cnt_reg[IDX_W-1:0];
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_RD:
            begin
                mem_rd     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            q_reg     <= '0;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            q_reg     <= q_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Digit store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            digit_store[cnt_reg[IDX_W-1:0]] <= div_rem;
        end
        if (mem_rd)
        begin
            rd_data_reg <= digit_store[ptr_reg];
        end
    end

    // Result word
    assign busy        = (state_reg != ST_IDLE);
    assign digit_valid = (state_reg == ST_OUT);
    assign digit       = rd_data_reg;
    assign last_digit  = (state_reg == ST_OUT) && (ptr_reg == '0);

    `ASSERT_CLK(a_valid_while_busy, digit_valid |-> busy)
    `ASSERT_CLK(a_last_with_valid, last_digit |-> digit_valid)
    `ASSERT_CLK(a_idle_after_last, (digit_valid && last_digit) |=> !busy)
    `ASSERT_CLK_MSG(a_digit_below_base, digit_valid |-> (digit < base_eff),
        "digit not below base")
    `ASSERT_CLK(a_done_only_dividing, div_done |-> (state_reg == ST_DIV))

endmodule
